// ===== rtl/nca_pkg.sv =====
// ============================================================================
// nca_pkg: shared types and constants for the nearest centroid accumulator
// Holds the sizes, the mode and state codes, and the structs that travel
// between the control logic and the row of centroid cells.
// ============================================================================
package nca_pkg;

	// Sizes of the stored state and the channel fields.
	localparam int MAX_CENTROIDS = 16;
	localparam int COORD_W       = 16;
	localparam int COUNT_W       = 20;
	localparam int SUM_W         = COORD_W + COUNT_W;
	localparam int IDX_W         = $clog2(MAX_CENTROIDS);
	localparam int CNT_W         = $clog2(MAX_CENTROIDS + 1);
	localparam int DIST_W        = 2 * COORD_W + 1;
	localparam int CFG_W         = 5;
	localparam int SLOT_W        = 4;
	localparam int MODE_W        = 2;
	localparam int OUT_IDX_W     = 4;

	// Operation codes carried in the mode field.
	localparam logic [MODE_W-1:0] MODE_LOAD   = 2'd0;
	localparam logic [MODE_W-1:0] MODE_ASSIGN = 2'd1;
	localparam logic [MODE_W-1:0] MODE_DUMP   = 2'd2;

	// Control sequencer states.
	typedef enum logic [2:0] {
		ST_IDLE,
		ST_DIST,
		ST_SCAN,
		ST_UPDATE,
		ST_EMIT,
		ST_DUMP
	} state_t;

	// Command broadcast from the control logic to every cell.
	typedef struct packed {
		logic                      load_en;
		logic                      upd_en;
		logic [IDX_W-1:0]          idx;
		logic signed [COORD_W-1:0] px;
		logic signed [COORD_W-1:0] py;
	} cell_cmd_t;

	// Running minimum handed from one cell to the next.
	typedef struct packed {
		logic              valid;
		logic [DIST_W-1:0] min_d;
		logic [IDX_W-1:0]  idx;
	} token_t;

	// Contents of one cluster slot.
	typedef struct packed {
		logic signed [COORD_W-1:0] cx;
		logic signed [COORD_W-1:0] cy;
		logic [COUNT_W-1:0]        cnt;
		logic signed [SUM_W-1:0]   sx;
		logic signed [SUM_W-1:0]   sy;
	} cell_state_t;

endpackage

// ===== rtl/nca_channels_if.sv =====
// ============================================================================
// nca channel interfaces: item, result and configuration channels
// Each channel carries valid, ready and its payload; a transaction completes
// at a rising clock edge where valid and ready are both high.
// ============================================================================
interface nca_in_if;
	logic                               valid;
	logic                               ready;
	logic [nca_pkg::MODE_W-1:0]         mode;
	logic [nca_pkg::SLOT_W-1:0]         cluster_slot;
	logic signed [nca_pkg::COORD_W-1:0] coord_x;
	logic signed [nca_pkg::COORD_W-1:0] coord_y;

	modport source (output valid, mode, cluster_slot, coord_x, coord_y, input ready);
	modport sink (input valid, mode, cluster_slot, coord_x, coord_y, output ready);
endinterface

interface nca_out_if;
	logic                               valid;
	logic                               ready;
	logic [nca_pkg::OUT_IDX_W-1:0]      cluster_id;
	logic signed [nca_pkg::COORD_W-1:0] centroid_x;
	logic signed [nca_pkg::COORD_W-1:0] centroid_y;
	logic [nca_pkg::COUNT_W-1:0]        point_count;
	logic signed [nca_pkg::SUM_W-1:0]   sum_x;
	logic signed [nca_pkg::SUM_W-1:0]   sum_y;
	logic                               last;

	modport source (output valid, cluster_id, centroid_x, centroid_y, point_count,
		sum_x, sum_y, last, input ready);
	modport sink (input valid, cluster_id, centroid_x, centroid_y, point_count,
		sum_x, sum_y, last, output ready);
endinterface

interface nca_cfg_if;
	logic                     valid;
	logic                     ready;
	logic [nca_pkg::CFG_W-1:0] data;

	modport source (output valid, data, input ready);
	modport sink (input valid, data, output ready);
endinterface

// ===== rtl/nca_cell.sv =====
// ============================================================================
// nca_cell: one centroid cell of the comparison row
// Holds one cluster's centroid, count and sums, computes the squared distance
// to the broadcast point, and passes the running minimum to its neighbor.
// ============================================================================
module nca_cell (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic [nca_pkg::IDX_W-1:0]     cell_id,
	input  logic [nca_pkg::CNT_W-1:0]     active_n,
	input  nca_pkg::cell_cmd_t            cmd,
	input  nca_pkg::token_t               tok_in,
	output nca_pkg::token_t               tok_out,
	output nca_pkg::cell_state_t          st
);

	nca_pkg::cell_state_t               st_q;
	logic                               tok_valid_q;
	logic [nca_pkg::DIST_W-1:0]         tok_min_q;
	logic [nca_pkg::IDX_W-1:0]          tok_idx_q;
	logic signed [nca_pkg::COORD_W:0]   dx_w;
	logic signed [nca_pkg::COORD_W:0]   dy_w;
	logic [nca_pkg::COORD_W-1:0]        adx;
	logic [nca_pkg::COORD_W-1:0]        ady;
	logic [2*nca_pkg::COORD_W-1:0]      sqx;
	logic [2*nca_pkg::COORD_W-1:0]      sqy;
	logic [nca_pkg::DIST_W-1:0]         d_q;
	logic                               active;
	logic                               win;
	logic                               hit;
	logic signed [nca_pkg::SUM_W-1:0]   px_ext;
	logic signed [nca_pkg::SUM_W-1:0]   py_ext;

	// Absolute coordinate differences and their squares.
	always_comb begin
		dx_w = {st_q.cx[nca_pkg::COORD_W-1], st_q.cx} - {cmd.px[nca_pkg::COORD_W-1], cmd.px};
		dy_w = {st_q.cy[nca_pkg::COORD_W-1], st_q.cy} - {cmd.py[nca_pkg::COORD_W-1], cmd.py};
		adx  = dx_w[nca_pkg::COORD_W] ? (~dx_w[nca_pkg::COORD_W-1:0] + 1'b1)
			: dx_w[nca_pkg::COORD_W-1:0];
		ady  = dy_w[nca_pkg::COORD_W] ? (~dy_w[nca_pkg::COORD_W-1:0] + 1'b1)
			: dy_w[nca_pkg::COORD_W-1:0];
		sqx  = adx * adx;
		sqy  = ady * ady;
	end

	// The squared distance is registered before it enters the comparison.
	always_ff @(posedge clk) begin
		d_q <= nca_pkg::DIST_W'(sqx) + nca_pkg::DIST_W'(sqy);
	end

	// Only active cells compete; a tie keeps the earlier, lower index.
	assign active = {1'b0, cell_id} < active_n;
	assign win    = active && ((cell_id == '0) || (d_q < tok_in.min_d));

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			tok_valid_q <= 1'b0;
		end else begin
			tok_valid_q <= tok_in.valid;
		end
	end

	always_ff @(posedge clk) begin
		if (win) begin
			tok_min_q <= d_q;
			tok_idx_q <= cell_id;
		end else begin
			tok_min_q <= tok_in.min_d;
			tok_idx_q <= tok_in.idx;
		end
	end

	// Cluster state: a load clears the totals, an assignment adds the point
	// until the count saturates.
	assign hit    = (cmd.idx == cell_id);
	assign px_ext = nca_pkg::SUM_W'(cmd.px);
	assign py_ext = nca_pkg::SUM_W'(cmd.py);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			st_q <= '0;
		end else if (cmd.load_en && hit) begin
			st_q.cx  <= cmd.px;
			st_q.cy  <= cmd.py;
			st_q.cnt <= '0;
			st_q.sx  <= '0;
			st_q.sy  <= '0;
		end else if (cmd.upd_en && hit && (st_q.cnt != '1)) begin
			st_q.cnt <= st_q.cnt + 1'b1;
			st_q.sx  <= st_q.sx + px_ext;
			st_q.sy  <= st_q.sy + py_ext;
		end
	end

	assign tok_out = {tok_valid_q, tok_min_q, tok_idx_q};
	assign st      = st_q;

endmodule

// ===== rtl/nearest_centroid_accumulator_unit.sv =====
// ============================================================================
// nearest_centroid_accumulator_unit: k-means assignment step on 2-D points
// A load is written into its cell as it is accepted. An assignment result passes
// a distance step, the ripple of the minimum down the row, a select step, an update
// step and an output load. A dump gives one result per cycle while the output
// register can load. One item is in work at a time; the next is taken in the cycle
// after the last result loads. Reset clears the store and sets the count to 16.
// ============================================================================
module nearest_centroid_accumulator_unit (
	input logic       clk,
	input logic       arst_n,
	nca_in_if.sink    item,
	nca_out_if.source result,
	nca_cfg_if.sink   cfg
);

	nca_pkg::state_t                  state_q;
	nca_pkg::state_t                  state_d;
	logic [nca_pkg::CFG_W-1:0]        cluster_count_q;
	logic [nca_pkg::CNT_W-1:0]        active_n;
	logic signed [nca_pkg::COORD_W-1:0] px_q;
	logic signed [nca_pkg::COORD_W-1:0] py_q;
	logic [nca_pkg::IDX_W-1:0]        sel_idx_q;
	logic                             start_q;
	logic                             item_acc;
	logic                             load_ok;
	logic                             dump_last;
	logic                             out_load;
	logic                             out_last;
	logic                             upd_en;
	logic                             in_ready;
	nca_pkg::cell_cmd_t               cmd;
	nca_pkg::token_t                  tok [nca_pkg::MAX_CENTROIDS+1];
	nca_pkg::cell_state_t             cell_st [nca_pkg::MAX_CENTROIDS];
	nca_pkg::cell_state_t             rd;

	logic                             out_valid_q;
	logic [nca_pkg::OUT_IDX_W-1:0]    out_idx_q;
	nca_pkg::cell_state_t             out_st_q;
	logic                             out_last_q;

	// Configuration register; the user must write it only while the unit is idle; the block does not enforce this.
	assign cfg.ready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cluster_count_q <= nca_pkg::CFG_W'(nca_pkg::MAX_CENTROIDS);
		end else if (cfg.valid) begin
			cluster_count_q <= cfg.data;
		end
	end

	// Clamp the cluster count into the range of existing cells.
	always_comb begin
		if (cluster_count_q == '0) begin
			active_n = nca_pkg::CNT_W'(1);
		end else if (int'(cluster_count_q) > nca_pkg::MAX_CENTROIDS) begin
			active_n = nca_pkg::CNT_W'(nca_pkg::MAX_CENTROIDS);
		end else begin
			active_n = nca_pkg::CNT_W'(cluster_count_q);
		end
	end

	assign item_acc  = item.valid && in_ready;
	assign load_ok   = !out_valid_q || result.ready;
	assign dump_last = (sel_idx_q == nca_pkg::IDX_W'(active_n - 1'b1));

	// Next-state logic of the sequencer.
	always_comb begin
		state_d = state_q;
		case (state_q)
			nca_pkg::ST_IDLE: begin
				if (item_acc && (item.mode == nca_pkg::MODE_ASSIGN)) begin
					state_d = nca_pkg::ST_DIST;
				end else if (item_acc && (item.mode == nca_pkg::MODE_DUMP)) begin
					state_d = nca_pkg::ST_DUMP;
				end
			end
			nca_pkg::ST_DIST: begin
				state_d = nca_pkg::ST_SCAN;
			end
			nca_pkg::ST_SCAN: begin
				if (tok[nca_pkg::MAX_CENTROIDS].valid) begin
					state_d = nca_pkg::ST_UPDATE;
				end
			end
			nca_pkg::ST_UPDATE: begin
				state_d = nca_pkg::ST_EMIT;
			end
			nca_pkg::ST_EMIT: begin
				if (load_ok) begin
					state_d = nca_pkg::ST_IDLE;
				end
			end
			nca_pkg::ST_DUMP: begin
				if (load_ok && dump_last) begin
					state_d = nca_pkg::ST_IDLE;
				end
			end
			default: begin
				state_d = nca_pkg::ST_IDLE;
			end
		endcase
	end

	// Output decode of the sequencer.
	always_comb begin
		in_ready = 1'b0;
		upd_en   = 1'b0;
		out_load = 1'b0;
		out_last = 1'b0;
		case (state_q)
			nca_pkg::ST_IDLE: begin
				in_ready = 1'b1;
			end
			nca_pkg::ST_UPDATE: begin
				upd_en = 1'b1;
			end
			nca_pkg::ST_EMIT: begin
				out_load = load_ok;
				out_last = 1'b1;
			end
			nca_pkg::ST_DUMP: begin
				out_load = load_ok;
				out_last = dump_last;
			end
			default: begin
				in_ready = 1'b0;
			end
		endcase
	end

	assign item.ready = in_ready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= nca_pkg::ST_IDLE;
			start_q <= 1'b0;
		end else begin
			state_q <= state_d;
			start_q <= (state_q == nca_pkg::ST_DIST);
		end
	end

	// Point capture and the selected cluster index.
	always_ff @(posedge clk) begin
		if (item_acc) begin
			px_q <= item.coord_x;
			py_q <= item.coord_y;
		end
		if (item_acc && (item.mode == nca_pkg::MODE_DUMP)) begin
			sel_idx_q <= '0;
		end else if (state_q == nca_pkg::ST_SCAN && tok[nca_pkg::MAX_CENTROIDS].valid) begin
			sel_idx_q <= tok[nca_pkg::MAX_CENTROIDS].idx;
		end else if (state_q == nca_pkg::ST_DUMP && load_ok && !dump_last) begin
			sel_idx_q <= sel_idx_q + 1'b1;
		end
	end

	// Command broadcast: loads come straight from the accepted item.
	always_comb begin
		cmd.load_en = item_acc && (item.mode == nca_pkg::MODE_LOAD)
			&& (int'(item.cluster_slot) < nca_pkg::MAX_CENTROIDS);
		cmd.upd_en  = upd_en;
		cmd.idx     = cmd.load_en ? nca_pkg::IDX_W'(item.cluster_slot) : sel_idx_q;
		cmd.px      = cmd.load_en ? item.coord_x : px_q;
		cmd.py      = cmd.load_en ? item.coord_y : py_q;
	end

	// The scan token enters the first cell in the cycle after the distance state, with the registered distances.
	assign tok[0] = {start_q, nca_pkg::DIST_W'(0), nca_pkg::IDX_W'(0)};

	// Row of centroid cells.
	for (genvar g = 0; g < nca_pkg::MAX_CENTROIDS; g++) begin : g_cell
		nca_cell u_cell (
			.clk      (clk),
			.arst_n   (arst_n),
			.cell_id  (nca_pkg::IDX_W'(g)),
			.active_n (active_n),
			.cmd      (cmd),
			.tok_in   (tok[g]),
			.tok_out  (tok[g+1]),
			.st       (cell_st[g])
		);
	end

	assign rd = cell_st[sel_idx_q];

	// Output register; it accepts a new result when empty or being drained.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (out_load) begin
			out_valid_q <= 1'b1;
		end else if (result.ready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (out_load) begin
			out_idx_q  <= nca_pkg::OUT_IDX_W'(sel_idx_q);
			out_st_q   <= rd;
			out_last_q <= out_last;
		end
	end

	assign result.valid       = out_valid_q;
	assign result.cluster_id  = out_idx_q;
	assign result.centroid_x  = out_st_q.cx;
	assign result.centroid_y  = out_st_q.cy;
	assign result.point_count = out_st_q.cnt;
	assign result.sum_x       = out_st_q.sx;
	assign result.sum_y       = out_st_q.sy;
	assign result.last        = out_last_q;

	// The winning cell is always one of the active ones.
	a_winner_active: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == nca_pkg::ST_SCAN && tok[nca_pkg::MAX_CENTROIDS].valid)
		|-> ({1'b0, tok[nca_pkg::MAX_CENTROIDS].idx} < active_n))
		else $error("winning cell index outside the active range");

	// A dump never walks past the last active cluster.
	a_dump_range: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == nca_pkg::ST_DUMP) |-> ({1'b0, sel_idx_q} < active_n))
		else $error("dump index outside the active range");

	// An assignment result is presented with its last flag set.
	a_assign_last: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == nca_pkg::ST_EMIT && load_ok) |=> (result.valid && result.last))
		else $error("assignment result missing or without last flag");

	// The scan token only starts right after the distance cycle.
	a_start_after_dist: assert property (@(posedge clk) disable iff (!arst_n)
		start_q |-> (state_q == nca_pkg::ST_SCAN && $past(state_q) == nca_pkg::ST_DIST))
		else $error("scan token started outside an assignment");

endmodule
